FILE: design/srds_pkg.sv
package srds_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int NAME_BYTES  = 32;

    typedef logic [NAME_BYTES*8-1:0] t_name;

    typedef struct packed {
        logic [63:0]       name_word0;
        logic [63:0]       name_word1;
        logic [63:0]       name_word2;
        logic [63:0]       name_word3;
        logic signed [7:0] signal_dbm;
        logic [3:0]        auth_code;
        logic              set_end;
    } t_in_word;

    typedef struct packed {
        logic [63:0]       out_word0;
        logic [63:0]       out_word1;
        logic [63:0]       out_word2;
        logic [63:0]       out_word3;
        logic signed [7:0] out_signal;
        logic [3:0]        out_auth;
        logic              empty_set;
        logic              run_last;
    } t_out_word;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic             wr_name_en;
        logic [IDX_W-1:0] wr_addr;
        t_name            wr_name;
        logic [7:0]       wr_sig;
        logic [3:0]       wr_auth;
    } t_mem_req;

    typedef struct packed {
        t_name      name;
        logic [7:0] sig;
        logic [3:0] auth;
    } t_mem_rd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SORT,
        S_SCAN,
        S_FETCH,
        S_LOAD,
        S_EMPTY
    } t_state;

endpackage

FILE: design/srds_norm.sv
module srds_norm (
    input  srds_pkg::t_in_word i_in,
    output srds_pkg::t_name    o_name
);

    srds_pkg::t_name                  raw;
    logic [srds_pkg::NAME_BYTES-1:0]  nz;
    logic [srds_pkg::NAME_BYTES-1:0]  keep;

    // a byte survives only if every byte before it is nonzero
    always_comb begin
        raw = {i_in.name_word3, i_in.name_word2, i_in.name_word1, i_in.name_word0};
        for (int b = 0; b < srds_pkg::NAME_BYTES; b++) begin
            nz[b] = (raw[b*8 +: 8] != 8'h00);
        end
        for (int b = 0; b < srds_pkg::NAME_BYTES; b++) begin
            keep[b] = &(nz | ({srds_pkg::NAME_BYTES{1'b1}} << b));
        end
        for (int b = 0; b < srds_pkg::NAME_BYTES; b++) begin
            o_name[b*8 +: 8] = keep[b] ? raw[b*8 +: 8] : 8'h00;
        end
    end

endmodule

FILE: design/srds_store.sv
module srds_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srds_pkg::t_mem_req i_req,
    output srds_pkg::t_mem_rd  o_rd
);

    srds_pkg::t_name r_name_mem [srds_pkg::MAX_ENTRIES];
    logic [11:0]     r_sa_mem   [srds_pkg::MAX_ENTRIES];
    srds_pkg::t_mem_rd r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_sa_mem[i_req.wr_addr] <= {i_req.wr_sig, i_req.wr_auth};
            if (i_req.wr_name_en) begin
                r_name_mem[i_req.wr_addr] <= i_req.wr_name;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd.name <= r_name_mem[i_req.rd_addr];
            r_rd.sig  <= r_sa_mem[i_req.rd_addr][11:4];
            r_rd.auth <= r_sa_mem[i_req.rd_addr][3:0];
        end
    end

    assign o_rd = r_rd;

    a_no_rw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.rd_en && i_req.wr_en |-> i_req.rd_addr != i_req.wr_addr)
        else $error("read and write hit the same entry");

endmodule

FILE: design/scan_record_dedup_sort.sv
// channel | dir | valid       | stall       | word
// in      | in  | i_in_valid  | o_in_stall  | i_in_word  (srds_pkg::t_in_word)
// out     | out | o_out_valid | i_out_stall | o_out_word (srds_pkg::t_out_word)
//
// Named record: one stored entry compared per cycle from the store.
// After set_end, each result takes a selection scan over the store, then one name fetch.
// Reset clears the state, the entry count and the valid flags; store contents are undefined until written.
// o_in_stall is high whenever a record or the result run is in progress.
// Results sit in an output register that holds while i_out_stall is high.
module scan_record_dedup_sort (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  srds_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output srds_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);

    srds_pkg::t_state                r_state, n_state;
    logic [srds_pkg::CNT_W-1:0]      r_count, n_count;
    logic [srds_pkg::CNT_W-1:0]      r_idx, n_idx;
    logic                            r_rd_vld, n_rd_vld;
    logic [srds_pkg::IDX_W-1:0]      r_rd_idx, n_rd_idx;
    logic                            r_best_vld, n_best_vld;
    logic [srds_pkg::IDX_W-1:0]      r_best_idx, n_best_idx;
    logic signed [7:0]               r_best_sig, n_best_sig;
    logic [srds_pkg::MAX_ENTRIES-1:0] r_done, n_done;
    logic [srds_pkg::CNT_W-1:0]      r_emit, n_emit;
    logic                            r_out_vld, n_out_vld;
    srds_pkg::t_out_word             r_out, n_out;
    srds_pkg::t_name                 r_name, n_name;
    logic [7:0]                      r_sig, n_sig;
    logic [3:0]                      r_auth, n_auth;
    logic                            r_last, n_last;

    srds_pkg::t_name                 norm_name;
    srds_pkg::t_mem_req              mem_req;
    srds_pkg::t_mem_rd               mem_rd;
    logic                            match;
    logic                            out_free;
    logic [srds_pkg::CNT_W-1:0]      emit_next;

    srds_norm u_norm (
        .i_in   (i_in_word),
        .o_name (norm_name)
    );

    srds_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rd    (mem_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= srds_pkg::S_IDLE;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rd_vld   <= n_rd_vld;
            r_best_vld <= n_best_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_best_idx <= n_best_idx;
        r_best_sig <= n_best_sig;
        r_done     <= n_done;
        r_emit     <= n_emit;
        r_out      <= n_out;
        r_name     <= n_name;
        r_sig      <= n_sig;
        r_auth     <= n_auth;
        r_last     <= n_last;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_idx[srds_pkg::IDX_W-1:0];
        n_best_vld = r_best_vld;
        n_best_idx = r_best_idx;
        n_best_sig = r_best_sig;
        n_done     = r_done;
        n_emit     = r_emit;
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_name     = r_name;
        n_sig      = r_sig;
        n_auth     = r_auth;
        n_last     = r_last;

        mem_req         = '0;
        mem_req.rd_addr = r_idx[srds_pkg::IDX_W-1:0];
        mem_req.wr_addr = r_rd_idx;
        mem_req.wr_name = r_name;
        mem_req.wr_sig  = r_sig;
        mem_req.wr_auth = r_auth;

        out_free  = !r_out_vld || !i_out_stall;
        match     = r_rd_vld && (mem_rd.name == r_name);
        emit_next = r_emit + srds_pkg::CNT_W'(1);

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            srds_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_name = norm_name;
                    n_sig  = i_in_word.signal_dbm;
                    n_auth = i_in_word.auth_code;
                    n_last = i_in_word.set_end;
                    n_idx  = '0;
                    if (norm_name[7:0] != 8'h00) begin
                        n_state = srds_pkg::S_SEARCH;
                    end else if (i_in_word.set_end) begin
                        n_state = srds_pkg::S_SORT;
                    end
                end
            end
            srds_pkg::S_SEARCH: begin
                if (match) begin
                    if ($signed(r_sig) > $signed(mem_rd.sig)) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = r_rd_idx;
                    end
                    n_state = r_last ? srds_pkg::S_SORT : srds_pkg::S_IDLE;
                end else if (r_idx < r_count) begin
                    mem_req.rd_en = 1'b1;
                    n_idx         = r_idx + srds_pkg::CNT_W'(1);
                    n_rd_vld      = 1'b1;
                end else if (!r_rd_vld) begin
                    // no match: append if room
                    if (r_count < srds_pkg::CNT_W'(srds_pkg::MAX_ENTRIES)) begin
                        mem_req.wr_en      = 1'b1;
                        mem_req.wr_name_en = 1'b1;
                        mem_req.wr_addr    = r_count[srds_pkg::IDX_W-1:0];
                        n_count            = r_count + srds_pkg::CNT_W'(1);
                    end
                    n_state = r_last ? srds_pkg::S_SORT : srds_pkg::S_IDLE;
                end
            end
            srds_pkg::S_SORT: begin
                n_done     = '0;
                n_emit     = '0;
                n_idx      = '0;
                n_best_vld = 1'b0;
                n_state    = (r_count == '0) ? srds_pkg::S_EMPTY : srds_pkg::S_SCAN;
            end
            srds_pkg::S_SCAN: begin
                // strictly greater keeps the earliest entry on ties
                if (r_rd_vld && !r_done[r_rd_idx] &&
                    (!r_best_vld || $signed(mem_rd.sig) > r_best_sig)) begin
                    n_best_vld = 1'b1;
                    n_best_idx = r_rd_idx;
                    n_best_sig = mem_rd.sig;
                end
                if (r_idx < r_count) begin
                    mem_req.rd_en = 1'b1;
                    n_idx         = r_idx + srds_pkg::CNT_W'(1);
                    n_rd_vld      = 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = srds_pkg::S_FETCH;
                end
            end
            srds_pkg::S_FETCH: begin
                if (!r_out_vld) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_best_idx;
                    n_state         = srds_pkg::S_LOAD;
                end
            end
            srds_pkg::S_LOAD: begin
                if (out_free) begin
                    n_out_vld            = 1'b1;
                    n_out.out_word0      = mem_rd.name[63:0];
                    n_out.out_word1      = mem_rd.name[127:64];
                    n_out.out_word2      = mem_rd.name[191:128];
                    n_out.out_word3      = mem_rd.name[255:192];
                    n_out.out_signal     = mem_rd.sig;
                    n_out.out_auth       = mem_rd.auth;
                    n_out.empty_set      = 1'b0;
                    n_out.run_last       = (emit_next == r_count);
                    n_done[r_best_idx]   = 1'b1;
                    n_emit               = emit_next;
                    n_idx                = '0;
                    n_best_vld           = 1'b0;
                    if (emit_next == r_count) begin
                        n_count = '0;
                        n_state = srds_pkg::S_IDLE;
                    end else begin
                        n_state = srds_pkg::S_SCAN;
                    end
                end
            end
            srds_pkg::S_EMPTY: begin
                if (out_free) begin
                    n_out_vld       = 1'b1;
                    n_out           = '0;
                    n_out.empty_set = 1'b1;
                    n_out.run_last  = 1'b1;
                    n_state         = srds_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srds_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != srds_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= srds_pkg::CNT_W'(srds_pkg::MAX_ENTRIES))
        else $error("entry count beyond capacity");

    a_done_tracks_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srds_pkg::S_SCAN || r_state == srds_pkg::S_FETCH ||
         r_state == srds_pkg::S_LOAD) |-> $countones(r_done) == r_emit)
        else $error("emitted mask out of step with emit count");

    a_load_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srds_pkg::S_FETCH || r_state == srds_pkg::S_LOAD) |->
        (r_best_vld && r_emit < r_count))
        else $error("fetch without a selected entry");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.empty_set |-> r_out.run_last && r_out.out_word0 == '0)
        else $error("empty-set word not flagged last");

endmodule
